// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ON_CLK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/ffa_pkg.sv =====
// Types, constants and codes of the first-fit region allocator.
`default_nettype none
package ffa_pkg;

  localparam int DESCRIPTORS_DEF = 32;
  localparam int OFFSET_BITS_DEF = 18;
  localparam int CAP_W           = 18;

  localparam logic [CAP_W-1:0] FAST_CAP_RST = 18'd19232;
  localparam logic [CAP_W-1:0] SLOW_CAP_RST = 18'd261120;

  localparam logic CFG_FAST = 1'b0;
  localparam logic CFG_SLOW = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DESC = 2'd1;
  localparam logic [1:0] ST_NO_GAP  = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  // Bit 1 of mode selects free, bit 0 selects the pool of an allocation.
  localparam int MODE_FREE_BIT = 1;
  localparam int MODE_POOL_BIT = 0;

  typedef struct packed {
    logic [1:0]  mode;
    logic        free_pool;
    logic [4:0]  handle;
    logic [17:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  granted_handle;
    logic [17:0] region_offset;
    logic [5:0]  blocks_in_use;
  } out_item_t;

  typedef struct packed {
    logic geo;
    logic nxt;
    logic prv;
  } wr_en_t;

endpackage
`default_nettype wire

// ===== rtl/first_fit_region_allocator_core.sv =====
// First-fit allocator over two pools of descriptors kept as address-ordered linked lists.
// The descriptor fields live in one memory with a registered read; busy bits, list heads and
// counts are flip-flops. An item is taken only when the sequencer is idle. A free of an unused
// handle, a zero size, a pool with no free descriptor and an empty list whose capacity is below
// the size go straight to the result; a free reads its descriptor, checks it and relinks both
// neighbours; an allocation into an empty list writes the new descriptor and relinks. Each
// neighbour step of the list walk is a memory read, a gap check and a check of the next link,
// and a fit before the head, in a gap or at the tail writes the new descriptor and relinks.
// The longest walk has DESCRIPTORS-2 steps. The next item can be taken in the cycle after the
// result is registered. A finished result waits in an output register while the next item is
// taken; a second result holds the sequencer until the output register drains.
`default_nettype none
`include "assert_macros.svh"
module first_fit_region_allocator_core import ffa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam int DESCRIPTORS = DESCRIPTORS_DEF;
  localparam int OFFSET_BITS = OFFSET_BITS_DEF;
  localparam int IW = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
  localparam int LW = $clog2(DESCRIPTORS + 1);
  localparam int AW = $clog2(2 * DESCRIPTORS);
  localparam int OW = OFFSET_BITS;
  localparam int CW = (OFFSET_BITS + 1 > CAP_W + 1) ? OFFSET_BITS + 1 : CAP_W + 1;
  localparam int HW = 10;
  localparam logic [LW-1:0] NIL = LW'(DESCRIPTORS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WALK, S_CHK, S_RD_GAP, S_GAP, S_RD_FREE, S_FREE_CHK,
    S_NEW, S_LK_PV, S_LK_NX, S_DONE
  } state_t;

  state_t state;

  logic [CAP_W-1:0]       cap [2];
  logic [DESCRIPTORS-1:0] busy [2];
  logic [LW-1:0]          head [2];
  logic [LW-1:0]          count [2];

  logic          pool;
  logic          is_free;
  logic [17:0]   isize;
  logic [IW-1:0] fidx;
  logic [IW-1:0] cur;
  logic [LW-1:0] prv_idx;
  logic          at_head;
  logic [CW-1:0] end_reg;
  logic [OW-1:0] new_off;
  logic [LW-1:0] pv_t;
  logic [LW-1:0] nx_t;
  logic [LW-1:0] lk_pv_val;
  logic [LW-1:0] lk_nx_val;
  logic [AW-1:0] rd_ptr;
  logic [1:0]    res_status;
  logic [4:0]    res_handle;
  logic [17:0]   res_offset;

  logic [OW-1:0] rd_off;
  logic [OW-1:0] rd_len;
  logic [LW-1:0] rd_next;
  logic [LW-1:0] rd_prev;
  logic [AW-1:0] wr_addr;
  wr_en_t        wr_en;
  logic [OW-1:0] wr_off;
  logic [OW-1:0] wr_len;
  logic [LW-1:0] wr_next;
  logic [LW-1:0] wr_prev;

  logic          ff_found;
  logic [IW-1:0] ff_idx;
  logic          in_acc;
  logic          in_pool;
  logic [CW-1:0] size_c;
  logic [CW-1:0] cap_c;
  logic [CW-1:0] rd_off_c;
  logic [CW-1:0] cur_end;
  logic          out_free;

  function automatic logic [AW-1:0] addr_of(input logic p, input logic [IW-1:0] i);
    addr_of = (p ? AW'(DESCRIPTORS) : AW'(0)) + AW'(i);
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign in_pool  = in_item.mode[MODE_POOL_BIT];
  assign size_c   = CW'(isize);
  assign cap_c    = CW'(cap[pool]);
  assign rd_off_c = CW'(rd_off);
  assign cur_end  = CW'(rd_off) + CW'(rd_len);
  assign out_free = !out_valid || !out_stall;

  ffa_free_find #(.D(DESCRIPTORS), .IW(IW)) u_free_find (
    .busy_row (busy[in_pool]),
    .found    (ff_found),
    .idx      (ff_idx)
  );

  ffa_desc_mem #(.DEPTH(2 * DESCRIPTORS), .AW(AW), .OW(OW), .LW(LW)) u_desc_mem (
    .clk     (clk),
    .rd_addr (rd_ptr),
    .rd_off  (rd_off),
    .rd_len  (rd_len),
    .rd_next (rd_next),
    .rd_prev (rd_prev),
    .wr_addr (wr_addr),
    .wr_en   (wr_en),
    .wr_off  (wr_off),
    .wr_len  (wr_len),
    .wr_next (wr_next),
    .wr_prev (wr_prev)
  );

  always_comb begin
    wr_addr = addr_of(pool, fidx);
    wr_en   = '0;
    wr_off  = new_off;
    wr_len  = OW'(isize);
    wr_next = nx_t;
    wr_prev = pv_t;
    unique case (state)
      S_NEW: begin
        wr_en = '{geo: 1'b1, nxt: 1'b1, prv: 1'b1};
      end
      S_LK_PV: begin
        wr_addr = addr_of(pool, IW'(pv_t));
        wr_next = lk_pv_val;
        wr_en.nxt = (pv_t != NIL);
      end
      S_LK_NX: begin
        wr_addr = addr_of(pool, IW'(nx_t));
        wr_prev = lk_nx_val;
        wr_en.prv = (nx_t != NIL);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cap[0]    <= FAST_CAP_RST;
      cap[1]    <= SLOW_CAP_RST;
      busy[0]   <= '0;
      busy[1]   <= '0;
      head[0]   <= NIL;
      head[1]   <= NIL;
      count[0]  <= '0;
      count[1]  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FAST: cap[0] <= cfg_data;
          CFG_SLOW: cap[1] <= cfg_data;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            res_status <= ST_OK;
            res_handle <= '0;
            res_offset <= '0;
            isize      <= in_item.request_bytes;
            if (in_item.mode[MODE_FREE_BIT]) begin
              is_free <= 1'b1;
              pool    <= in_item.free_pool;
              fidx    <= IW'(in_item.handle);
              if (HW'(in_item.handle) >= HW'(DESCRIPTORS) ||
                  !busy[in_item.free_pool][IW'(in_item.handle)]) begin
                res_status <= ST_UNUSED;
                state      <= S_DONE;
              end else begin
                rd_ptr <= addr_of(in_item.free_pool, IW'(in_item.handle));
                state  <= S_RD_FREE;
              end
            end else begin
              is_free <= 1'b0;
              pool    <= in_pool;
              fidx    <= ff_idx;
              if (in_item.request_bytes == '0) begin
                res_status <= ST_NO_GAP;
                state      <= S_DONE;
              end else if (!ff_found) begin
                res_status <= ST_NO_DESC;
                state      <= S_DONE;
              end else if (head[in_pool] == NIL) begin
                if (CW'(in_item.request_bytes) > CW'(cap[in_pool])) begin
                  res_status <= ST_NO_GAP;
                  state      <= S_DONE;
                end else begin
                  new_off   <= '0;
                  pv_t      <= NIL;
                  nx_t      <= NIL;
                  lk_pv_val <= LW'(ff_idx);
                  lk_nx_val <= LW'(ff_idx);
                  state     <= S_NEW;
                end
              end else begin
                rd_ptr  <= addr_of(in_pool, IW'(head[in_pool]));
                cur     <= IW'(head[in_pool]);
                at_head <= 1'b1;
                state   <= S_RD_WALK;
              end
            end
          end
        end
        S_RD_WALK: state <= S_CHK;
        S_CHK: begin
          lk_pv_val <= LW'(fidx);
          lk_nx_val <= LW'(fidx);
          if (at_head && rd_off_c >= size_c) begin
            new_off <= '0;
            pv_t    <= NIL;
            nx_t    <= LW'(cur);
            state   <= S_NEW;
          end else if (rd_next == NIL) begin
            // Tail gap; a capacity below the last region leaves no room.
            if (cap_c > cur_end && (cap_c - cur_end) >= size_c) begin
              new_off <= OW'(cur_end);
              pv_t    <= LW'(cur);
              nx_t    <= NIL;
              state   <= S_NEW;
            end else begin
              res_status <= ST_NO_GAP;
              state      <= S_DONE;
            end
          end else begin
            end_reg <= cur_end;
            prv_idx <= LW'(cur);
            cur     <= IW'(rd_next);
            rd_ptr  <= addr_of(pool, IW'(rd_next));
            at_head <= 1'b0;
            state   <= S_RD_GAP;
          end
        end
        S_RD_GAP: state <= S_GAP;
        S_GAP: begin
          if (rd_off_c > end_reg && (rd_off_c - end_reg) >= size_c) begin
            new_off <= OW'(end_reg);
            pv_t    <= prv_idx;
            nx_t    <= LW'(cur);
            state   <= S_NEW;
          end else begin
            // Read data still holds this descriptor: check its own successor.
            state <= S_CHK;
          end
        end
        S_RD_FREE: state <= S_FREE_CHK;
        S_FREE_CHK: begin
          pv_t      <= rd_prev;
          nx_t      <= rd_next;
          lk_pv_val <= rd_next;
          lk_nx_val <= rd_prev;
          busy[pool][fidx] <= 1'b0;
          state <= S_LK_PV;
        end
        S_NEW: begin
          busy[pool][fidx] <= 1'b1;
          res_handle       <= 5'(fidx);
          res_offset       <= 18'(new_off);
          state            <= S_LK_PV;
        end
        S_LK_PV: begin
          // Move the count together with the head so the two always agree.
          if (pv_t == NIL) begin
            head[pool] <= lk_pv_val;
          end
          if (is_free) begin
            if (count[pool] != '0) begin
              count[pool] <= count[pool] - LW'(1);
            end
          end else begin
            count[pool] <= count[pool] + LW'(1);
          end
          state <= S_LK_NX;
        end
        S_LK_NX: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_item.status         <= res_status;
            out_item.granted_handle <= res_handle;
            out_item.region_offset  <= res_offset;
            out_item.blocks_in_use  <= 6'(count[pool]);
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ON_CLK(a_head_cnt0, (head[0] == NIL) == (count[0] == '0), "pool 0 head and count disagree")
  `ASSERT_ON_CLK(a_head_cnt1, (head[1] == NIL) == (count[1] == '0), "pool 1 head and count disagree")
  `ASSERT_IMPLIES(a_err_zero, out_valid && out_item.status != ST_OK, out_item.granted_handle == '0 && out_item.region_offset == '0, "failed item carries a handle or offset")

endmodule
`default_nettype wire

// ===== rtl/ffa_desc_mem.sv =====
// Descriptor memory: offset, length and links, one read and one field-masked write port.
`default_nettype none
module ffa_desc_mem import ffa_pkg::*; #(
  parameter int DEPTH = 2 * DESCRIPTORS_DEF,
  parameter int AW    = 6,
  parameter int OW    = OFFSET_BITS_DEF,
  parameter int LW    = 6
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [OW-1:0] rd_off,
  output logic      [OW-1:0] rd_len,
  output logic      [LW-1:0] rd_next,
  output logic      [LW-1:0] rd_prev,
  input  wire logic [AW-1:0] wr_addr,
  input  wire wr_en_t        wr_en,
  input  wire logic [OW-1:0] wr_off,
  input  wire logic [OW-1:0] wr_len,
  input  wire logic [LW-1:0] wr_next,
  input  wire logic [LW-1:0] wr_prev
);

  logic [OW-1:0] mem_off  [DEPTH];
  logic [OW-1:0] mem_len  [DEPTH];
  logic [LW-1:0] mem_next [DEPTH];
  logic [LW-1:0] mem_prev [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.geo) begin
      mem_off[wr_addr] <= wr_off;
      mem_len[wr_addr] <= wr_len;
    end
    if (wr_en.nxt) begin
      mem_next[wr_addr] <= wr_next;
    end
    if (wr_en.prv) begin
      mem_prev[wr_addr] <= wr_prev;
    end
    rd_off  <= mem_off[rd_addr];
    rd_len  <= mem_len[rd_addr];
    rd_next <= mem_next[rd_addr];
    rd_prev <= mem_prev[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ffa_free_find.sv =====
// Lowest free descriptor of one pool.
`default_nettype none
module ffa_free_find import ffa_pkg::*; #(
  parameter int D  = DESCRIPTORS_DEF,
  parameter int IW = 5
) (
  input  wire logic [D-1:0]  busy_row,
  output logic               found,
  output logic      [IW-1:0] idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    // Scan downwards so the lowest free entry wins.
    for (int i = D - 1; i >= 0; i--) begin
      if (!busy_row[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/first_fit_region_allocator_core_tb.sv =====
// Testbench for the two-pool first-fit region allocator core.
`default_nettype none
module first_fit_region_allocator_core_tb;
  import ffa_pkg::*;

  localparam int NDESC = 32;
  localparam int NIL = NDESC;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int BLOCK_LATENCY = 3 * NDESC + 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_FAST;
  logic [CAP_W-1:0] cfg_data = '0;

  first_fit_region_allocator_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted allocator state
  logic [CAP_W-1:0] pool_cap [2];
  logic             desc_busy [2][NDESC];
  logic [17:0]      desc_ofs  [2][NDESC];
  logic [17:0]      desc_len  [2][NDESC];
  int               desc_next [2][NDESC];
  int               desc_prev [2][NDESC];
  int               list_head [2];
  int               busy_count [2];

  out_item_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int ok_allocs = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  int hold_cycles = 0;

  function automatic out_item_t make_result(logic [1:0] st, int h, logic [17:0] ofs, int p);
    out_item_t r;
    r.status = st;
    r.granted_handle = h[4:0];
    r.region_offset = ofs;
    r.blocks_in_use = busy_count[p][5:0];
    return r;
  endfunction

  function automatic void claim(int p, int f, logic [17:0] ofs, logic [17:0] sz, int pv, int nx);
    desc_busy[p][f] = 1'b1;
    desc_ofs[p][f] = ofs;
    desc_len[p][f] = sz;
    desc_prev[p][f] = pv;
    desc_next[p][f] = nx;
    busy_count[p]++;
  endfunction

  function automatic out_item_t predict_alloc(int p, logic [17:0] sz);
    int f;
    int cur;
    int nx;
    longint fin;
    longint gap;
    longint cap;
    f = NIL;
    cap = pool_cap[p];
    if (sz == 0) return make_result(ST_NO_GAP, 0, 0, p);
    for (int i = NDESC - 1; i >= 0; i--) if (!desc_busy[p][i]) f = i;
    if (f == NIL) return make_result(ST_NO_DESC, 0, 0, p);
    if (list_head[p] == NIL) begin
      if (sz > cap) return make_result(ST_NO_GAP, 0, 0, p);
      claim(p, f, 0, sz, NIL, NIL);
      list_head[p] = f;
      return make_result(ST_OK, f, 0, p);
    end
    if (desc_ofs[p][list_head[p]] >= sz) begin
      claim(p, f, 0, sz, NIL, list_head[p]);
      desc_prev[p][list_head[p]] = f;
      list_head[p] = f;
      return make_result(ST_OK, f, 0, p);
    end
    cur = list_head[p];
    while (desc_next[p][cur] != NIL) begin
      nx = desc_next[p][cur];
      fin = longint'(desc_ofs[p][cur]) + desc_len[p][cur];
      gap = desc_ofs[p][nx] > fin ? desc_ofs[p][nx] - fin : 0;
      if (gap >= sz) begin
        claim(p, f, fin[17:0], sz, cur, nx);
        desc_prev[p][nx] = f;
        desc_next[p][cur] = f;
        return make_result(ST_OK, f, fin[17:0], p);
      end
      cur = nx;
    end
    fin = longint'(desc_ofs[p][cur]) + desc_len[p][cur];
    gap = cap > fin ? cap - fin : 0;
    if (gap < sz) return make_result(ST_NO_GAP, 0, 0, p);
    claim(p, f, fin[17:0], sz, cur, NIL);
    desc_next[p][cur] = f;
    return make_result(ST_OK, f, fin[17:0], p);
  endfunction

  function automatic out_item_t predict_free(int p, int h);
    int pv;
    int nx;
    if (!desc_busy[p][h]) return make_result(ST_UNUSED, 0, 0, p);
    pv = desc_prev[p][h];
    nx = desc_next[p][h];
    if (pv == NIL) list_head[p] = nx;
    else desc_next[p][pv] = nx;
    if (nx != NIL) desc_prev[p][nx] = pv;
    desc_busy[p][h] = 1'b0;
    if (busy_count[p] > 0) busy_count[p]--;
    return make_result(ST_OK, 0, 0, p);
  endfunction

  function automatic out_item_t predict_item(in_item_t it);
    if (it.mode[MODE_FREE_BIT]) return predict_free(int'(it.free_pool), int'(it.handle));
    return predict_alloc(int'(it.mode[MODE_POOL_BIT]), it.request_bytes);
  endfunction

  // Always move on to a fresh falling edge before the next item is driven
  task automatic idle_gap();
    int n;
    n = 1;
    if (idle_on && $urandom_range(0, 3) == 0) n = $urandom_range(1, 8);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_item(logic [1:0] mode, logic fp, logic [4:0] h, logic [17:0] sz);
    in_item_t it;
    it.mode = mode;
    it.free_pool = fp;
    it.handle = h;
    it.request_bytes = sz;
    idle_gap();
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_item(it));
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_cap(logic idx, logic [CAP_W-1:0] val);
    wait_drained();
    repeat (BLOCK_LATENCY) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    pool_cap[idx] = val;
  endtask

  // Pick a busy handle most of the time so frees do real unlinking
  function automatic logic [4:0] pick_handle(int p);
    int tries;
    logic [4:0] h;
    h = 5'($urandom_range(0, 31));
    for (tries = 0; tries < 8 && !desc_busy[p][h]; tries++) h = 5'($urandom_range(0, 31));
    return h;
  endfunction

  function automatic logic [17:0] pick_size(int p);
    case ($urandom_range(0, 9))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, 3));
      2: return pool_cap[p];
      default: return 18'($urandom_range(1, (pool_cap[p] / 12) + 1));
    endcase
  endfunction

  task automatic random_items(int count, int free_pct);
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 1);
      if ($urandom_range(0, 99) < free_pct)
        send_item($urandom_range(0, 1) ? 2'd3 : 2'd2, p[0], pick_handle(p), 18'($urandom));
      else
        send_item({1'b0, p[0]}, 1'($urandom), 5'($urandom), pick_size(p));
    end
  endtask

  task automatic test_directed();
    send_item(2'd0, 1'b0, 5'd0, 18'd0);
    send_item(2'd1, 1'b1, 5'd31, 18'h3FFFF);
    send_item(2'd0, 1'b0, 5'd0, 18'd19232);
    send_item(2'd2, 1'b0, 5'd0, 18'd0);
    send_item(2'd1, 1'b0, 5'd0, 18'd100);
    send_item(2'd1, 1'b1, 5'd0, 18'd200);
    send_item(2'd1, 1'b0, 5'd0, 18'd300);
    send_item(2'd2, 1'b1, 5'd1, 18'd0);
    send_item(2'd1, 1'b0, 5'd0, 18'd150);
    send_item(2'd1, 1'b0, 5'd0, 18'd50);
    send_item(2'd3, 1'b1, 5'd0, 18'h3FFFF);
    send_item(2'd1, 1'b0, 5'd0, 18'd100);
    send_item(2'd2, 1'b1, 5'd31, 18'd0);
    send_item(2'd3, 1'b0, 5'd17, 18'd0);
  endtask

  // Fill the fast pool to all descriptors, then one more; then free every second one and allocate again
  task automatic test_full_pool();
    write_cap(CFG_FAST, 18'h3FFFF);
    for (int i = 0; i < NDESC + 1; i++) send_item(2'd0, 1'b0, 5'd0, 18'd1);
    for (int i = 0; i < NDESC; i += 2) send_item(2'd2, 1'b0, 5'(i), 18'd0);
    send_item(2'd0, 1'b0, 5'd0, 18'd2);
    send_item(2'd0, 1'b0, 5'd0, 18'd1);
  endtask

  // Lower capacity below regions in use
  task automatic test_capacity_change();
    write_cap(CFG_FAST, 18'd1);
    write_cap(CFG_SLOW, 18'd1);
    send_item(2'd0, 1'b0, 5'd0, 18'd1);
    send_item(2'd1, 1'b0, 5'd0, 18'd1);
    send_item(2'd1, 1'b0, 5'd0, 18'd1);
    for (int i = 0; i < NDESC; i++) send_item(2'd2, 1'b0, 5'(i), 18'd0);
    for (int i = 0; i < NDESC; i++) send_item(2'd2, 1'b1, 5'(i), 18'd0);
    send_item(2'd0, 1'b0, 5'd0, 18'd2);
    send_item(2'd0, 1'b0, 5'd0, 18'd1);
  endtask

  task automatic test_random();
    write_cap(CFG_FAST, 18'd4096);
    write_cap(CFG_SLOW, 18'h3FFFF);
    random_items(300, 35);
    wait_drained();
    write_cap(CFG_FAST, 18'd19232);
    write_cap(CFG_SLOW, 18'd500);
    random_items(250, 45);
    write_cap(CFG_SLOW, 18'd261120);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    random_items(60, 40);
    long_hold = 1'b0;
    wait_drained();
    random_items(40, 40);
  endtask

  task automatic test_steady();
    idle_on = 1'b0;
    random_items(300, 40);
  endtask

  // Receiver: random stalls, plus one long hold while the sender keeps going
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold && hold_cycles == 0) begin
        out_stall <= 1'b1;
        while (hold_cycles < 600) begin
          @(negedge clk);
          hold_cycles++;
        end
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_OK && want.blocks_in_use != 0 && want.granted_handle != 0)
          ok_allocs++;
        if (out_item.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_item.status);
        if (out_item.granted_handle !== want.granted_handle)
          $display("%0t: granted_handle expected %0d actual %0d", $time,
                   want.granted_handle, out_item.granted_handle);
        if (out_item.region_offset !== want.region_offset)
          $display("%0t: region_offset expected %0d actual %0d", $time,
                   want.region_offset, out_item.region_offset);
        if (out_item.blocks_in_use !== want.blocks_in_use)
          $display("%0t: blocks_in_use expected %0d actual %0d", $time,
                   want.blocks_in_use, out_item.blocks_in_use);
        if (out_item !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pool_cap[0] = FAST_CAP_RST;
    pool_cap[1] = SLOW_CAP_RST;
    for (int p = 0; p < 2; p++) begin
      list_head[p] = NIL;
      busy_count[p] = 0;
      for (int i = 0; i < NDESC; i++) desc_busy[p][i] = 1'b0;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_pool();
    test_capacity_change();
    test_random();
    test_backpressure();
    test_steady();
    wait_drained();
    repeat (BLOCK_LATENCY) @(negedge clk);
    $display("covered %0d items and %0d results: both pools, exhaustion, frees of unused",
             items_sent, results_seen);
    $display("handles, shrunken capacities, a long output hold and steady back-to-back traffic");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== first_fit_region_allocator_core.f =====
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_desc_mem.sv
rtl/ffa_free_find.sv
rtl/first_fit_region_allocator_core.sv
test/first_fit_region_allocator_core_tb.sv
